[rtl/tms_pkg.sv]
package tms_pkg;

	localparam int NUM_STREAMS = 8;
	localparam int MASK_BITS   = 8;
	localparam int IDX_W       = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
	localparam int STREAM_W    = 3;
	localparam int SEC_W       = 32;
	localparam int FRAC_W      = 30;
	localparam int TS_W        = 62;
	localparam int CFG_W       = 8;
	localparam int CFG_IDX_W   = 1;

	localparam logic [FRAC_W-1:0] NS_PER_SEC = 30'd1000000000;
	localparam logic [FRAC_W-1:0] US_SCALE   = 30'd1000;
	localparam logic [FRAC_W-1:0] NS_SCALE   = 30'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_LIVE_MASK = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_USEC_MASK = 1'b1;

	localparam logic REQ_HEAD = 1'b0;
	localparam logic REQ_END  = 1'b1;

	typedef struct packed {
		logic                req_type;
		logic [STREAM_W-1:0] stream_index;
		logic [SEC_W-1:0]    ts_sec;
		logic [FRAC_W-1:0]   ts_frac;
	} in_item_t;

	typedef struct packed {
		logic [STREAM_W-1:0] winner_stream;
		logic [TS_W-1:0]     merged_timestamp;
		logic                all_done;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_SEC,
		ST_MUL_FRAC,
		ST_ADD,
		ST_WRITE,
		ST_SCAN,
		ST_RESULT
	} state_t;

	// sequencer -> datapath
	typedef struct packed {
		logic mul_en;
		logic frac_sel;
		logic acc_load;
		logic acc_add;
		logic head_wr;
		logic scan_clr;
		logic scan_step;
		logic result;
	} ctrl_t;

	// datapath -> sequencer
	typedef struct packed {
		logic in_valid;
		logic head_go;
		logic scan_last;
		logic out_free;
	} status_t;

endpackage

[rtl/tms_mul_unit.sv]
// Shared multiplier with accumulator: sec * 1e9, then frac * scale, then sum.
module tms_mul_unit (
	input  logic                          clk,
	input  tms_pkg::ctrl_t                ctrl,
	input  logic [tms_pkg::SEC_W-1:0]     sec,
	input  logic [tms_pkg::FRAC_W-1:0]    frac,
	input  logic [tms_pkg::FRAC_W-1:0]    scale,
	output logic [tms_pkg::TS_W-1:0]      acc
);

	logic [tms_pkg::SEC_W-1:0]                 op_a;
	logic [tms_pkg::FRAC_W-1:0]                op_b;
	logic [tms_pkg::SEC_W+tms_pkg::FRAC_W-1:0] prod_c;
	logic [tms_pkg::SEC_W+tms_pkg::FRAC_W-1:0] prod_s1;
	logic [tms_pkg::TS_W-1:0]                  acc_q;

	always_comb begin
		op_a = ctrl.frac_sel ? tms_pkg::SEC_W'(frac) : sec;
		op_b = ctrl.frac_sel ? scale : tms_pkg::NS_PER_SEC;
	end

	assign prod_c = op_a * op_b;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= prod_c;
		end
		if (ctrl.acc_load) begin
			acc_q <= tms_pkg::TS_W'(prod_s1);
		end else if (ctrl.acc_add) begin
			acc_q <= acc_q + tms_pkg::TS_W'(prod_s1);
		end
	end

	assign acc = acc_q;

endmodule

[rtl/tms_ctrl.sv]
// Item sequencer: convert head time for a taken head, scan all slots, hand off result.
module tms_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  tms_pkg::status_t status,
	output tms_pkg::ctrl_t   ctrl,
	output logic             in_ready
);

	tms_pkg::state_t state_q;
	tms_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tms_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tms_pkg::ST_IDLE: begin
				if (status.in_valid) begin
					state_d = status.head_go ? tms_pkg::ST_MUL_SEC : tms_pkg::ST_SCAN;
				end
			end
			tms_pkg::ST_MUL_SEC:  state_d = tms_pkg::ST_MUL_FRAC;
			tms_pkg::ST_MUL_FRAC: state_d = tms_pkg::ST_ADD;
			tms_pkg::ST_ADD:      state_d = tms_pkg::ST_WRITE;
			tms_pkg::ST_WRITE:    state_d = tms_pkg::ST_SCAN;
			tms_pkg::ST_SCAN: begin
				if (status.scan_last) begin
					state_d = tms_pkg::ST_RESULT;
				end
			end
			tms_pkg::ST_RESULT: begin
				if (status.out_free) begin
					state_d = tms_pkg::ST_IDLE;
				end
			end
			default: state_d = tms_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl     = '0;
		in_ready = 1'b0;
		unique case (state_q)
			tms_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				ctrl.scan_clr = status.in_valid;
			end
			tms_pkg::ST_MUL_SEC: begin
				ctrl.mul_en = 1'b1;
			end
			tms_pkg::ST_MUL_FRAC: begin
				ctrl.mul_en   = 1'b1;
				ctrl.frac_sel = 1'b1;
				ctrl.acc_load = 1'b1;
			end
			tms_pkg::ST_ADD: begin
				ctrl.acc_add = 1'b1;
			end
			tms_pkg::ST_WRITE: begin
				ctrl.head_wr  = 1'b1;
				ctrl.scan_clr = 1'b1;
			end
			tms_pkg::ST_SCAN: begin
				ctrl.scan_step = 1'b1;
			end
			tms_pkg::ST_RESULT: begin
				ctrl.result = status.out_free;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

endmodule

[rtl/timestamp_merge_selector_core.sv]
// Sequence: a head that is taken passes through the conversion states MUL_SEC, MUL_FRAC,
// ADD and WRITE on the shared multiplier, any other item skips them; every item then scans
// all NUM_STREAMS slots with the single slot comparator and ends in the decision state, which
// waits for a free output. A new item is taken only once the sequencer is back in idle.
// Reset (arst_n low, asynchronous): masks, ended and present flags, sequencer and output
// valid clear at once; held head times are not cleared and are read only while present.
module timestamp_merge_selector_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  tms_pkg::in_item_t                in_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output tms_pkg::out_item_t               out_item,
	input  logic                             cfg_we,
	input  logic [tms_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tms_pkg::CFG_W-1:0]        cfg_data
);

	// configuration
	logic [tms_pkg::MASK_BITS-1:0] live_mask_q;
	logic [tms_pkg::MASK_BITS-1:0] usec_mask_q;

	// per-stream state
	logic [tms_pkg::NUM_STREAMS-1:0] ended_q;
	logic [tms_pkg::NUM_STREAMS-1:0] present_q;
	logic [tms_pkg::TS_W-1:0]        head_time_q [tms_pkg::NUM_STREAMS];

	// item held during conversion
	logic [tms_pkg::NUM_STREAMS-1:0] sel_q;
	logic [tms_pkg::SEC_W-1:0]       sec_q;
	logic [tms_pkg::FRAC_W-1:0]      frac_q;
	logic [tms_pkg::FRAC_W-1:0]      scale_q;

	// scan registers
	logic [tms_pkg::IDX_W-1:0] idx_q;
	logic                      found_q;
	logic                      pending_q;
	logic                      waiting_q;
	logic [tms_pkg::IDX_W-1:0] best_q;
	logic [tms_pkg::TS_W-1:0]  best_t_q;

	// output register
	logic               out_valid_q;
	tms_pkg::out_item_t out_item_q;

	logic [tms_pkg::NUM_STREAMS-1:0] live_vec;
	logic [tms_pkg::NUM_STREAMS-1:0] sel_in;
	logic [tms_pkg::NUM_STREAMS-1:0] win_oh;
	logic                            in_acc;
	logic                            in_live;
	logic                            head_go;
	logic                            end_go;
	logic                            cur_live;
	logic                            cur_end;
	logic                            cur_pres;
	logic [tms_pkg::TS_W-1:0]        cur_t;
	logic                            emit_pkt;
	logic                            emit_done;
	logic [tms_pkg::TS_W-1:0]        acc;
	tms_pkg::ctrl_t                  ctrl;
	tms_pkg::status_t                status;

	// Slot decode. Streams at or above the mask width are never live.
	always_comb begin
		for (int i = 0; i < tms_pkg::NUM_STREAMS; i++) begin
			live_vec[i] = (i < tms_pkg::MASK_BITS) && live_mask_q[i % tms_pkg::MASK_BITS];
			sel_in[i]   = (i < tms_pkg::MASK_BITS) &&
			              (in_item.stream_index == tms_pkg::STREAM_W'(i));
			win_oh[i]   = (best_q == tms_pkg::IDX_W'(i));
		end
	end

	assign in_acc  = in_valid && in_ready;
	assign in_live = |(sel_in & live_vec);
	// a head is taken only for a live stream that has not ended and has no head yet
	assign head_go = (in_item.req_type == tms_pkg::REQ_HEAD) && in_live &&
	                 !(|(sel_in & ended_q)) && !(|(sel_in & present_q));
	// an end is ignored while the stream still holds a head
	assign end_go  = (in_item.req_type == tms_pkg::REQ_END) && in_live &&
	                 !(|(sel_in & present_q));

	// current scan slot
	assign cur_live = live_vec[idx_q];
	assign cur_end  = ended_q[idx_q];
	assign cur_pres = present_q[idx_q];
	assign cur_t    = head_time_q[idx_q];

	// decision after the full scan
	assign emit_pkt  = found_q && !waiting_q;
	assign emit_done = !found_q && !pending_q;

	always_comb begin
		status.in_valid  = in_valid;
		status.head_go   = head_go;
		status.scan_last = (idx_q == tms_pkg::IDX_W'(tms_pkg::NUM_STREAMS - 1));
		status.out_free  = !out_valid_q || out_ready;
	end

	tms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.ctrl     (ctrl),
		.in_ready (in_ready)
	);

	tms_mul_unit u_mul (
		.clk   (clk),
		.ctrl  (ctrl),
		.sec   (sec_q),
		.frac  (frac_q),
		.scale (scale_q),
		.acc   (acc)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_mask_q <= '0;
			usec_mask_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tms_pkg::CFG_LIVE_MASK: live_mask_q <= cfg_data;
				tms_pkg::CFG_USEC_MASK: usec_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// held item fields for the conversion passes
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sel_q   <= sel_in;
			sec_q   <= in_item.ts_sec;
			frac_q  <= in_item.ts_frac;
			scale_q <= usec_mask_q[in_item.stream_index] ? tms_pkg::US_SCALE
			                                             : tms_pkg::NS_SCALE;
		end
	end

	// ended and present flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q   <= '0;
			present_q <= '0;
		end else begin
			if (in_acc && end_go) begin
				ended_q <= ended_q | sel_in;
			end
			if (ctrl.head_wr) begin
				present_q <= present_q | sel_q;
			end else if (ctrl.result && emit_pkt) begin
				present_q <= present_q & ~win_oh;
			end
		end
	end

	// head time slots, no reset
	always_ff @(posedge clk) begin
		for (int i = 0; i < tms_pkg::NUM_STREAMS; i++) begin
			if (ctrl.head_wr && sel_q[i]) begin
				head_time_q[i] <= acc;
			end
		end
	end

	// one slot per cycle through the comparator; ties keep the lower index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			found_q   <= 1'b0;
			pending_q <= 1'b0;
			waiting_q <= 1'b0;
		end else if (ctrl.scan_clr) begin
			idx_q     <= '0;
			found_q   <= 1'b0;
			pending_q <= 1'b0;
			waiting_q <= 1'b0;
		end else if (ctrl.scan_step) begin
			idx_q <= idx_q + 1'b1;
			if (cur_live) begin
				if (!cur_end) begin
					pending_q <= 1'b1;
					if (!cur_pres) begin
						waiting_q <= 1'b1;
					end
				end
				if (cur_pres && (!found_q || (cur_t < best_t_q))) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.scan_step && cur_live && cur_pres && (!found_q || (cur_t < best_t_q))) begin
			best_q   <= idx_q;
			best_t_q <= cur_t;
		end
	end

	// output register: the next item may be taken while this one waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.result && (emit_pkt || emit_done)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.result && emit_pkt) begin
			out_item_q.winner_stream    <= tms_pkg::STREAM_W'(best_q);
			out_item_q.merged_timestamp <= best_t_q;
			out_item_q.all_done         <= 1'b0;
		end else if (ctrl.result && emit_done) begin
			out_item_q.winner_stream    <= '0;
			out_item_q.merged_timestamp <= '0;
			out_item_q.all_done         <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTH
	// the winning slot must still hold a live head when it is released
	a_win_present: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.result && emit_pkt) |-> (present_q[best_q] && live_vec[best_q]))
		else $error("winner slot holds no live head");

	// every accepted item takes the sequencer out of idle, so ready drops
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready high right after an accepted item");

	// a result only appears from the decision step
	a_out_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctrl.result))
		else $error("output valid rose outside the decision step");
`endif

endmodule

[sim/merge_scoreboard_pkg.sv]
package merge_scoreboard_pkg;

	import tms_pkg::*;

	// Tracks the merge state and keeps the results still owed by the block.
	class merge_scoreboard;

		logic [MASK_BITS-1:0] live_mask;
		logic [MASK_BITS-1:0] usec_mask;
		bit                   ended[NUM_STREAMS];
		bit                   present[NUM_STREAMS];
		longint unsigned      head_ns[NUM_STREAMS];
		out_item_t            owed_q[$];
		int unsigned          errors;

		function new();
			live_mask = '0;
			usec_mask = '0;
			errors    = 0;
			for (int s = 0; s < NUM_STREAMS; s++) begin
				ended[s]   = 1'b0;
				present[s] = 1'b0;
				head_ns[s] = 0;
			end
		endfunction

		function void set_mask(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == CFG_LIVE_MASK)
				live_mask = val;
			else
				usec_mask = val;
		endfunction

		// stream could take a head right now
		function bit is_free(int s);
			return live_mask[s] && !ended[s] && !present[s];
		endfunction

		function bit any_unended();
			for (int s = 0; s < NUM_STREAMS; s++)
				if (!ended[s])
					return 1'b1;
			return 1'b0;
		endfunction

		// Applies one accepted item; returns 1 when it changed state or owes a result.
		function bit note_input(in_item_t it);
			int              s;
			int              best;
			bit              waiting;
			bit              pending;
			bit              found;
			bit              took;
			longint unsigned best_t;
			longint unsigned scale;
			out_item_t       res;
			s       = int'(it.stream_index);
			took    = 1'b0;
			waiting = 1'b0;
			pending = 1'b0;
			found   = 1'b0;
			best    = 0;
			best_t  = 0;
			if (s < NUM_STREAMS && live_mask[s]) begin
				if (it.req_type == REQ_HEAD) begin
					if (!ended[s] && !present[s]) begin
						scale      = usec_mask[s] ? 64'(US_SCALE) : 64'(NS_SCALE);
						head_ns[s] = 64'(it.ts_sec) * 64'(NS_PER_SEC) + 64'(it.ts_frac) * scale;
						present[s] = 1'b1;
						took       = 1'b1;
					end
				end else if (!present[s] && !ended[s]) begin
					ended[s] = 1'b1;
					took     = 1'b1;
				end
			end
			for (int i = 0; i < NUM_STREAMS; i++) begin
				if (live_mask[i]) begin
					if (!ended[i]) begin
						pending = 1'b1;
						if (!present[i])
							waiting = 1'b1;
					end
					if (present[i] && (!found || head_ns[i] < best_t)) begin
						found  = 1'b1;
						best   = i;
						best_t = head_ns[i];
					end
				end
			end
			if (found) begin
				if (waiting)
					return took;
				present[best]        = 1'b0;
				res.winner_stream    = STREAM_W'(best);
				res.merged_timestamp = best_t[TS_W-1:0];
				res.all_done         = 1'b0;
				owed_q.push_back(res);
				return 1'b1;
			end
			if (!pending) begin
				res.winner_stream    = '0;
				res.merged_timestamp = '0;
				res.all_done         = 1'b1;
				owed_q.push_back(res);
				return 1'b1;
			end
			return took;
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (owed_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result stream %0d ts %0d done %0b",
					got.winner_stream, got.merged_timestamp, got.all_done));
				return;
			end
			want = owed_q.pop_front();
			if (got.winner_stream !== want.winner_stream)
				report_mismatch($sformatf("winner_stream got %0d want %0d",
					got.winner_stream, want.winner_stream));
			if (got.merged_timestamp !== want.merged_timestamp)
				report_mismatch($sformatf("merged_timestamp got %0d want %0d",
					got.merged_timestamp, want.merged_timestamp));
			if (got.all_done !== want.all_done)
				report_mismatch($sformatf("all_done got %0b want %0b",
					got.all_done, want.all_done));
		endtask

	endclass

endpackage

[sim/tb_timestamp_merge_selector_core.sv]
module tb_timestamp_merge_selector_core;
	timeunit 1ns;
	timeprecision 1ps;

	import tms_pkg::*;
	import merge_scoreboard_pkg::*;

	localparam int RUN_ITEMS     = 1700;   // items that do something
	localparam int SETTLE_CYCLES = 20;     // lets an item with no result finish
	localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
	localparam int CYCLE_LIMIT   = 600000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_item   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_LIVE_MASK;
	logic [CFG_W-1:0]     cfg_data  = '0;

	merge_scoreboard sb;
	int unsigned     cycles       = 0;
	int unsigned     applied      = 0;
	bit              quiet        = 1'b0;   // no idling on either side
	bit              hold_pending = 1'b0;

	timestamp_merge_selector_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_timestamp_merge_selector_core: FAIL");
			$finish;
		end
	end

	// Result side: values sampled at the edge are the pre-edge ones, same as the DUT sees.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_item);
	end

	// Receiver: ready bursts and stall bursts; one long hold-off on request.
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	function automatic in_item_t mk_item(logic req, int s, logic [SEC_W-1:0] sec,
		logic [FRAC_W-1:0] frac);
		in_item_t it;
		it.req_type     = req;
		it.stream_index = STREAM_W'(s);
		it.ts_sec       = sec;
		it.ts_frac      = frac;
		return it;
	endfunction

	function automatic int pick_free_stream();
		int cand[$];
		for (int s = 0; s < NUM_STREAMS; s++)
			if (sb.is_free(s))
				cand.push_back(s);
		if (cand.size() == 0)
			return -1;
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	// Head times cluster around a per-phase second so ties and near-ties show up;
	// a us fraction of 1 equals an ns fraction of 1000.
	function automatic in_item_t make_head(int s, logic [SEC_W-1:0] base_sec);
		logic [SEC_W-1:0]  sec;
		logic [FRAC_W-1:0] frac;
		bit                usec;
		usec = sb.usec_mask[s];
		if ($urandom_range(0, 3) == 0)
			sec = $urandom;
		else
			sec = base_sec + $urandom_range(0, 2);
		case ($urandom_range(0, 3))
			0: frac = FRAC_W'($urandom);   // may exceed the nominal range
			1: frac = usec ? FRAC_W'($urandom_range(0, 999999))
				: FRAC_W'($urandom_range(0, 999999999));
			2: begin
				case ($urandom_range(0, 3))
					0: frac = '0;
					1: frac = 30'd1;
					2: frac = 30'd1000;
					default: frac = 30'd999999;
				endcase
			end
			default: frac = usec ? 30'd999999 : 30'd999999999;
		endcase
		return mk_item(REQ_HEAD, s, sec, frac);
	endfunction

	// Random item; an end that would finish a waiting stream becomes a head so that
	// stream ends stay planned (an ended stream never comes back).
	function automatic in_item_t make_noise();
		in_item_t it;
		it = mk_item(1'($urandom_range(0, 1)), $urandom_range(0, NUM_STREAMS - 1), $urandom,
			FRAC_W'($urandom));
		if (it.req_type == REQ_END && sb.is_free(int'(it.stream_index)))
			it.req_type = REQ_HEAD;
		return it;
	endfunction

	// Offer one item, with an occasional gap first; valid stays up until accepted.
	task automatic offer(in_item_t it);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do
			@(posedge clk);
		while (!in_ready);
		if (sb.note_input(it))
			applied++;
	endtask

	// Wait until every owed result is out, then let an item with no result finish.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.owed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_masks(logic [CFG_W-1:0] live, logic [CFG_W-1:0] usec);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LIVE_MASK;
		cfg_data  <= live;
		@(posedge clk);
		sb.set_mask(CFG_LIVE_MASK, live);
		cfg_index <= CFG_USEC_MASK;
		cfg_data  <= usec;
		@(posedge clk);
		sb.set_mask(CFG_USEC_MASK, usec);
		cfg_we    <= 1'b0;
	endtask

	task automatic directed();
		// masks at reset value: nothing live, so every item answers done
		offer(mk_item(REQ_HEAD, 3, 32'd1, 30'd1));
		offer(mk_item(REQ_END, 5, 32'd0, 30'd0));
		drain();
		write_masks(8'hFF, 8'hAA);     // odd streams in us
		offer(mk_item(REQ_HEAD, 0, 32'd0, 30'd0));
		offer(mk_item(REQ_HEAD, 1, 32'hFFFF_FFFF, 30'h3FFF_FFFF));   // largest time
		offer(mk_item(REQ_HEAD, 2, 32'hFFFF_FFFF, 30'd999999999));
		offer(mk_item(REQ_HEAD, 3, 32'd7, 30'd5));                   // us, ties with s4
		offer(mk_item(REQ_HEAD, 4, 32'd7, 30'd5000));
		offer(mk_item(REQ_HEAD, 5, 32'd7, 30'd999999));              // us, ties with s6
		offer(mk_item(REQ_HEAD, 6, 32'd7, 30'd999999000));
		offer(mk_item(REQ_HEAD, 0, 32'd1, 30'd1));      // slot busy: ignored
		offer(mk_item(REQ_END, 1, 32'd0, 30'd0));       // head held: ignored
		offer(mk_item(REQ_HEAD, 7, 32'd0, 30'd0));      // tie at zero, s0 wins
		offer(mk_item(REQ_HEAD, 0, 32'd1, 30'd0));      // s7 goes out
		offer(mk_item(REQ_END, 7, 32'd0, 30'd0));       // s7 ends, s0 goes out
		offer(mk_item(REQ_HEAD, 7, 32'd5, 30'd5));      // ended stream: ignored
		offer(mk_item(REQ_HEAD, 0, 32'hFFFF_FFFF, 30'd0));
		offer(mk_item(REQ_HEAD, 3, 32'd7, 30'd5));
		offer(mk_item(REQ_END, 6, 32'd0, 30'd0));       // head held: ignored
	endtask

	// One setting of the masks, then well-formed merge traffic mixed with noise.
	// end_at >= 0 retires one waiting stream at that position; hold asks the
	// receiver for its long hold-off once the traffic of this phase starts.
	task automatic run_phase(logic [CFG_W-1:0] live, logic [CFG_W-1:0] usec, int n,
		int end_at, bit hold);
		logic [SEC_W-1:0] base_sec;
		int               s;
		drain();
		write_masks(live, usec);
		if (hold)
			hold_pending = 1'b1;
		case ($urandom_range(0, 3))
			0: base_sec = '0;
			1: base_sec = 32'hFFFF_FFFD;
			default: base_sec = $urandom_range(0, 32'hFFFF_FFFD);
		endcase
		for (int i = 0; i < n; i++) begin
			s = pick_free_stream();
			if (i == end_at && s >= 0)
				offer(mk_item(REQ_END, s, $urandom, FRAC_W'($urandom)));
			else if (s >= 0 && $urandom_range(0, 99) < 80)
				offer(make_head(s, base_sec));
			else
				offer(make_noise());
		end
	endtask

	// Everything live, streams retire one by one until the merge reports done.
	task automatic wind_down();
		int s;
		drain();
		write_masks(8'hFF, CFG_W'($urandom));
		quiet = 1'b1;
		while (sb.any_unended()) begin
			s = pick_free_stream();
			if (s >= 0 && $urandom_range(0, 99) < 25)
				offer(mk_item(REQ_END, s, $urandom, FRAC_W'($urandom)));
			else if (s >= 0 && $urandom_range(0, 99) < 90)
				offer(make_head(s, $urandom));
			else
				offer(make_noise());
		end
		repeat (10) offer(make_noise());   // done repeats for every item
	endtask

	initial begin
		int               phase;
		int               n;
		int               end_at;
		logic [CFG_W-1:0] live;
		logic [CFG_W-1:0] usec;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed();

		phase = 0;
		while (applied < RUN_ITEMS) begin
			phase++;
			n    = $urandom_range(30, 90);
			live = CFG_W'($urandom);
			usec = CFG_W'($urandom);
			case (phase % 8)
				0: begin
					live = 8'hFF;
					usec = 8'h00;
				end
				1: begin
					live = 8'hFF;
					usec = 8'hFF;
				end
				2: begin
					// nothing live: every item answers done, so the output backs up
					live = 8'h00;
					n    = 20;
				end
				3: usec = 8'h00;
				default: ;
			endcase
			end_at = (phase == 9 || phase == 19) ? $urandom_range(0, n - 1) : -1;
			run_phase(live, usec, n, end_at, phase == 2);
		end

		wind_down();
		drain();

		if (sb.errors == 0)
			$display("tb_timestamp_merge_selector_core: PASS");
		else
			$display("tb_timestamp_merge_selector_core: FAIL");
		$finish;
	end

endmodule
